// ===== design/soab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soab_pkg: shared types and constants for the scaled overlay blender
// Register indexes, field widths, and the output word and configuration structs.
// ----------------------------------------------------------------------------
package soab_pkg;

  localparam int unsigned MaxOverlayW = 128;
  localparam int unsigned MaxOverlayH = 128;
  localparam int unsigned CoordBits   = 12;
  localparam int unsigned RegBits     = 13;

  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_RW     = 3'd2,
    REG_RH     = 3'd3,
    REG_OW     = 3'd4,
    REG_OH     = 3'd5,
    REG_SWAP   = 3'd6,
    REG_UNUSED = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic [7:0] out3;
    logic       blended;
  } out_word_t;

  typedef struct packed {
    logic signed [RegBits-1:0] region_left;
    logic signed [RegBits-1:0] region_top;
    logic [RegBits-1:0]        region_w;
    logic [RegBits-1:0]        region_h;
    logic [7:0]                overlay_w;
    logic [7:0]                overlay_h;
    logic                      swap_rb;
  } cfg_t;

  // (d*(255-a) + s*a) / 255 for sums up to 255*255, as reciprocal multiply
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    begin
      t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
      div255 = t[15:8] + {7'd0, t[16]};
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/soab_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soab_in_if / soab_out_if: valid-ready channels
// Input channel carries one pixel or texel word, output one result word.
// ----------------------------------------------------------------------------
interface soab_in_if #(parameter int unsigned COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [7:0]            chan0;
  logic [7:0]            chan1;
  logic [7:0]            chan2;
  logic [7:0]            chan3;
  modport source (output valid, opcode, pos_x, pos_y, chan0, chan1, chan2, chan3,
                  input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, chan0, chan1, chan2, chan3,
                  output ready);
endinterface

interface soab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out0;
  logic [7:0] out1;
  logic [7:0] out2;
  logic [7:0] out3;
  logic       blended;
  modport source (output valid, out0, out1, out2, out3, blended, input ready);
  modport sink   (input valid, out0, out1, out2, out3, blended, output ready);
endinterface
`default_nettype wire

// ===== design/soab_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soab_regs: APB configuration registers
// Holds region and overlay geometry; reads return the stored value.
// ----------------------------------------------------------------------------
module soab_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output soab_pkg::cfg_t    cfg_o
);
  import soab_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_left <= '0;
      cfg_q.region_top  <= '0;
      cfg_q.region_w    <= RegBits'(1);
      cfg_q.region_h    <= RegBits'(1);
      cfg_q.overlay_w   <= 8'd1;
      cfg_q.overlay_h   <= 8'd1;
      cfg_q.swap_rb     <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_LEFT:   cfg_q.region_left <= pwdata[RegBits-1:0];
        REG_TOP:    cfg_q.region_top  <= pwdata[RegBits-1:0];
        REG_RW:     cfg_q.region_w    <= pwdata[RegBits-1:0];
        REG_RH:     cfg_q.region_h    <= pwdata[RegBits-1:0];
        REG_OW:     cfg_q.overlay_w   <= pwdata[7:0];
        REG_OH:     cfg_q.overlay_h   <= pwdata[7:0];
        REG_SWAP:   cfg_q.swap_rb     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_LEFT: prdata = {{(32-RegBits){cfg_q.region_left[RegBits-1]}}, cfg_q.region_left};
      REG_TOP:  prdata = {{(32-RegBits){cfg_q.region_top[RegBits-1]}}, cfg_q.region_top};
      REG_RW:   prdata = {{(32-RegBits){1'b0}}, cfg_q.region_w};
      REG_RH:   prdata = {{(32-RegBits){1'b0}}, cfg_q.region_h};
      REG_OW:   prdata = {24'd0, cfg_q.overlay_w};
      REG_OH:   prdata = {24'd0, cfg_q.overlay_h};
      REG_SWAP: prdata = {31'd0, cfg_q.swap_rb};
      default:  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/soab_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soab_div: pipelined restoring divider
// One quotient bit per stage; advances only when en_i is high.
// ----------------------------------------------------------------------------
module soab_div #(
  parameter int unsigned NUM_BITS = 21,
  parameter int unsigned DEN_BITS = 13,
  parameter int unsigned Q_BITS   = 11
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [NUM_BITS-1:0] num_i,
  input  wire logic [DEN_BITS-1:0] den_i,
  output logic [Q_BITS-1:0]        quot_o
);
  localparam int unsigned RemBits = DEN_BITS + 1;

  // stage k holds remainder, numerator, denominator and quotient so far
  logic [RemBits-1:0]  rem_q [Q_BITS+1];
  logic [NUM_BITS-1:0] num_q [Q_BITS+1];
  logic [DEN_BITS-1:0] den_q [Q_BITS+1];
  logic [Q_BITS-1:0]   quo_q [Q_BITS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // quotient < 2^Q_BITS, so the top bits divide to zero and stay remainder
      rem_q[0] <= RemBits'(num_i >> Q_BITS);
      num_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    logic [RemBits-1:0] trial;
    logic [RemBits:0]   diff;
    assign trial = {rem_q[k][RemBits-2:0], num_q[k][Q_BITS-1-k]};
    assign diff  = {1'b0, trial} - {2'b00, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= diff[RemBits] ? trial : diff[RemBits-1:0];
        num_q[k+1] <= num_q[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= {quo_q[k][Q_BITS-2:0], ~diff[RemBits]};
      end
    end
  end

  assign quot_o = quo_q[Q_BITS];

endmodule
`default_nettype wire

// ===== design/soab_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soab_blend: per-channel alpha mix
// Two stages: products, then sum and divide by 255.
// ----------------------------------------------------------------------------
module soab_blend (
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire logic [7:0] d_i,
  input  wire logic [7:0] s_i,
  input  wire logic [7:0] a_i,
  output logic [7:0]      mix_o
);
  import soab_pkg::*;

  logic [15:0] pd_q, ps_q;
  logic [15:0] sum;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pd_q <= d_i * (8'd255 - a_i);
      ps_q <= s_i * a_i;
    end
  end

  assign sum = pd_q + ps_q;  // <= 255*255, fits

  always_ff @(posedge clk_i) begin
    if (en_i) mix_o <= div255(sum);
  end

endmodule
`default_nettype wire

// ===== design/scaled_overlay_alpha_blend_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_overlay_alpha_blend_top: scaled RGBA overlay blender
// Nearest-neighbor scaling of a texel memory onto a region of the frame.
// ----------------------------------------------------------------------------
// Accepts one word per clock while the output is not stalled, load or pixel
// alike, through 16 register stages (default sizes): an offset and region-test
// stage, a 13x8-bit scale product stage, the divider's input register and its
// 8 quotient stages, an address/clamp stage, the texel memory read, two blend
// stages and the output register. Texel loads travel down the same pipe,
// write the memory at the read stage and yield no word, so every pixel sees
// exactly the loads that came before it. The whole pipe advances when the
// output register is empty or being taken, so a stall holds everything in
// place and delays every word by the stalled cycles. The texel memory has no
// reset; unwritten texels read as garbage.
module scaled_overlay_alpha_blend_top #(
  parameter int unsigned MAX_OVERLAY_W = soab_pkg::MaxOverlayW,
  parameter int unsigned MAX_OVERLAY_H = soab_pkg::MaxOverlayH,
  parameter int unsigned COORD_BITS    = soab_pkg::CoordBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  soab_in_if.sink          in_if,
  soab_out_if.source       out_if
);
  import soab_pkg::*;

  localparam int unsigned XBits  = $clog2(MAX_OVERLAY_W);
  localparam int unsigned YBits  = $clog2(MAX_OVERLAY_H);
  localparam int unsigned XW     = (XBits > 0) ? XBits : 1;
  localparam int unsigned YW     = (YBits > 0) ? YBits : 1;
  localparam int unsigned AddrW  = XW + YW;
  localparam int unsigned Depth  = 1 << AddrW;
  localparam int unsigned OffW   = RegBits + 1;
  localparam int unsigned SzW    = $clog2(((MAX_OVERLAY_W > MAX_OVERLAY_H) ?
                                            MAX_OVERLAY_W : MAX_OVERLAY_H) + 1);
  localparam int unsigned NumW   = RegBits + SzW;
  localparam int unsigned QW     = SzW;            // quotient < overlay size
  localparam int unsigned DivLat = QW + 1;

  cfg_t cfg;
  logic adv;

  soab_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // saturated overlay size
  logic [SzW-1:0] ow_sat, oh_sat;
  always_comb begin
    if (cfg.overlay_w == 8'd0) ow_sat = SzW'(1);
    else if ({24'd0, cfg.overlay_w} > 32'(MAX_OVERLAY_W)) ow_sat = SzW'(MAX_OVERLAY_W);
    else ow_sat = SzW'(cfg.overlay_w);
    if (cfg.overlay_h == 8'd0) oh_sat = SzW'(1);
    else if ({24'd0, cfg.overlay_h} > 32'(MAX_OVERLAY_H)) oh_sat = SzW'(MAX_OVERLAY_H);
    else oh_sat = SzW'(cfg.overlay_h);
  end

  // ---------------- stage 1: offsets and region test
  logic signed [OffW+COORD_BITS-1:0] offx, offy;
  assign offx = $signed({1'b0, in_if.pos_x}) - cfg.region_left;
  assign offy = $signed({1'b0, in_if.pos_y}) - cfg.region_top;

  logic            v1_q, in1_q;
  logic [RegBits-1:0] ox1_q, oy1_q;
  logic [31:0]     px1_q;
  logic            ld1_q;
  logic [AddrW-1:0] la1_q;
  logic            inx, iny;
  assign inx = !offx[OffW+COORD_BITS-1] &&
               (offx < $signed({{(OffW+COORD_BITS-RegBits){1'b0}}, cfg.region_w}));
  assign iny = !offy[OffW+COORD_BITS-1] &&
               (offy < $signed({{(OffW+COORD_BITS-RegBits){1'b0}}, cfg.region_h}));

  // texel loads ride the pipe and write at the read stage, keeping word order
  logic [31:0] tex_mem [Depth];
  logic        ld;
  assign ld = in_if.valid && (in_if.opcode == OP_LOAD) &&
              ({{(32-COORD_BITS){1'b0}}, in_if.pos_x} < 32'(MAX_OVERLAY_W)) &&
              ({{(32-COORD_BITS){1'b0}}, in_if.pos_y} < 32'(MAX_OVERLAY_H));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      ld1_q <= 1'b0;
    end else if (adv) begin
      v1_q  <= in_if.valid && (in_if.opcode == OP_PIXEL);
      ld1_q <= ld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in1_q <= inx && iny;
      ox1_q <= offx[RegBits-1:0];
      oy1_q <= offy[RegBits-1:0];
      px1_q <= {in_if.chan3, in_if.chan2, in_if.chan1, in_if.chan0};
      la1_q <= {in_if.pos_y[YW-1:0], in_if.pos_x[XW-1:0]};
    end
  end

  // ---------------- stage 2: scale products
  logic            v2_q, in2_q;
  logic [NumW-1:0] nx2_q, ny2_q;
  logic [31:0]     px2_q;
  logic            ld2_q;
  logic [AddrW-1:0] la2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      ld2_q <= 1'b0;
    end else if (adv) begin
      v2_q  <= v1_q;
      ld2_q <= ld1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in2_q <= in1_q;
      nx2_q <= ox1_q * ow_sat;
      ny2_q <= oy1_q * oh_sat;
      px2_q <= px1_q;
      la2_q <= la1_q;
    end
  end

  // ---------------- dividers
  logic [QW-1:0] qx, qy;
  soab_div #(.NUM_BITS(NumW), .DEN_BITS(RegBits), .Q_BITS(QW)) u_divx (
    .clk_i, .en_i(adv), .num_i(nx2_q), .den_i(cfg.region_w), .quot_o(qx)
  );
  soab_div #(.NUM_BITS(NumW), .DEN_BITS(RegBits), .Q_BITS(QW)) u_divy (
    .clk_i, .en_i(adv), .num_i(ny2_q), .den_i(cfg.region_h), .quot_o(qy)
  );

  // side pipe matching divider latency
  logic             vd_q  [DivLat];
  logic             ind_q [DivLat];
  logic [31:0]      pxd_q [DivLat];
  logic             ldd_q [DivLat];
  logic [AddrW-1:0] lad_q [DivLat];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivLat; i++) begin
        vd_q[i]  <= 1'b0;
        ldd_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vd_q[0]  <= v2_q;
      ldd_q[0] <= ld2_q;
      for (int i = 1; i < DivLat; i++) begin
        vd_q[i]  <= vd_q[i-1];
        ldd_q[i] <= ldd_q[i-1];
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ind_q[0] <= in2_q;
      pxd_q[0] <= px2_q;
      lad_q[0] <= la2_q;
      for (int i = 1; i < DivLat; i++) begin
        ind_q[i] <= ind_q[i-1];
        pxd_q[i] <= pxd_q[i-1];
        lad_q[i] <= lad_q[i-1];
      end
    end
  end

  // ---------------- stage: clamp and address
  logic [QW-1:0] sx, sy;
  assign sx = (qx > ow_sat - SzW'(1)) ? ow_sat - SzW'(1) : qx;
  assign sy = (qy > oh_sat - SzW'(1)) ? oh_sat - SzW'(1) : qy;

  logic             va_q, ina_q, lda_q;
  logic [AddrW-1:0] addr_q;
  logic [31:0]      pxa_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      lda_q <= 1'b0;
    end else if (adv) begin
      va_q  <= vd_q[DivLat-1];
      lda_q <= ldd_q[DivLat-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ina_q  <= ind_q[DivLat-1];
      addr_q <= ldd_q[DivLat-1] ? lad_q[DivLat-1] : {sy[YW-1:0], sx[XW-1:0]};
      pxa_q  <= pxd_q[DivLat-1];
    end
  end

  // ---------------- stage: memory read, load write
  logic        vm_q, inm_q;
  logic [31:0] tex_q, pxm_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else if (adv) vm_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (lda_q) tex_mem[addr_q] <= pxa_q;
      inm_q <= ina_q;
      tex_q <= tex_mem[addr_q];
      pxm_q <= pxa_q;
    end
  end

  // ---------------- blend (two stages)
  logic [7:0] s0, s2, m0, m1, m2;
  assign s0 = cfg.swap_rb ? tex_q[23:16] : tex_q[7:0];
  assign s2 = cfg.swap_rb ? tex_q[7:0]   : tex_q[23:16];

  soab_blend u_b0 (.clk_i, .en_i(adv), .d_i(pxm_q[7:0]),   .s_i(s0),
                   .a_i(tex_q[31:24]), .mix_o(m0));
  soab_blend u_b1 (.clk_i, .en_i(adv), .d_i(pxm_q[15:8]),  .s_i(tex_q[15:8]),
                   .a_i(tex_q[31:24]), .mix_o(m1));
  soab_blend u_b2 (.clk_i, .en_i(adv), .d_i(pxm_q[23:16]), .s_i(s2),
                   .a_i(tex_q[31:24]), .mix_o(m2));

  logic        vb_q [2];
  logic        hb_q [2];
  logic [31:0] pxb_q [2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q[0] <= 1'b0;
      vb_q[1] <= 1'b0;
    end else if (adv) begin
      vb_q[0] <= vm_q;
      vb_q[1] <= vb_q[0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hb_q[0]  <= inm_q && (tex_q[31:24] != 8'd0);
      hb_q[1]  <= hb_q[0];
      pxb_q[0] <= pxm_q;
      pxb_q[1] <= pxb_q[0];
    end
  end

  // ---------------- output register
  logic      ov_q;
  out_word_t ow_q, ow_d;
  always_comb begin
    ow_d.blended = hb_q[1];
    if (hb_q[1]) begin
      ow_d.out0 = m0;
      ow_d.out1 = m1;
      ow_d.out2 = m2;
      ow_d.out3 = 8'd255;
    end else begin
      ow_d.out0 = pxb_q[1][7:0];
      ow_d.out1 = pxb_q[1][15:8];
      ow_d.out2 = pxb_q[1][23:16];
      ow_d.out3 = pxb_q[1][31:24];
    end
  end

  assign adv = !ov_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= vb_q[1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) ow_q <= ow_d;
  end

  assign in_if.ready    = adv;
  assign out_if.valid   = ov_q;
  assign out_if.out0    = ow_q.out0;
  assign out_if.out1    = ow_q.out1;
  assign out_if.out2    = ow_q.out2;
  assign out_if.out3    = ow_q.out3;
  assign out_if.blended = ow_q.blended;

endmodule
`default_nettype wire

// ===== test/soab_blend_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soab_blend_checker: result predictor and comparator for the overlay blender
// Follows register writes and texel loads, predicts each pixel word
// and compares it with what the output channel delivers, oldest first.
// ----------------------------------------------------------------------------
module soab_blend_checker
  import soab_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  soab_in_if          in_ch,
  soab_out_if         out_ch,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned StoreDepth = MaxOverlayW * MaxOverlayH;

  logic [31:0] texels [StoreDepth];
  cfg_t        cfg_q;
  out_word_t   blend_q [$];

  assign pending_o = blend_q.size();

  function automatic int clamp_size(int v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // nearest texel index along one axis, -1 when outside the region
  function automatic int texel_index(int pos, int edge_pos, int rsize, int osize);
    int off;
    int s;
    off = pos - edge_pos;
    if (rsize == 0 || off < 0 || off >= rsize) return -1;
    s = (off * osize) / rsize;
    return (s > osize - 1) ? osize - 1 : s;
  endfunction

  function automatic logic [7:0] mix(int d, int s, int a);
    return 8'((d * (255 - a) + s * a) / 255);
  endfunction

  function automatic out_word_t blend_pixel(int px, int py, logic [7:0] c0,
                                            logic [7:0] c1, logic [7:0] c2,
                                            logic [7:0] c3);
    out_word_t   w;
    int          sx;
    int          sy;
    logic [31:0] t;
    logic [7:0]  src0;
    logic [7:0]  src2;
    w = '{out0: c0, out1: c1, out2: c2, out3: c3, blended: 1'b0};
    sx = texel_index(px, int'(cfg_q.region_left), int'(cfg_q.region_w),
                     clamp_size(int'(cfg_q.overlay_w), MaxOverlayW));
    sy = texel_index(py, int'(cfg_q.region_top), int'(cfg_q.region_h),
                     clamp_size(int'(cfg_q.overlay_h), MaxOverlayH));
    if (sx < 0 || sy < 0) return w;
    t = texels[sy * MaxOverlayW + sx];
    if (t[31:24] == 8'd0) return w;
    src0 = cfg_q.swap_rb ? t[23:16] : t[7:0];
    src2 = cfg_q.swap_rb ? t[7:0] : t[23:16];
    w.out0 = mix(c0, src0, t[31:24]);
    w.out1 = mix(c1, t[15:8], t[31:24]);
    w.out2 = mix(c2, src2, t[31:24]);
    w.out3 = 8'd255;
    w.blended = 1'b1;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    out_word_t got;
    if (!rst_ni) begin
      cfg_q <= '{region_left: '0, region_top: '0, region_w: 13'd1, region_h: 13'd1,
                 overlay_w: 8'd1, overlay_h: 8'd1, swap_rb: 1'b0};
      blend_q.delete();
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_LEFT: cfg_q.region_left <= pwdata[RegBits-1:0];
          REG_TOP:  cfg_q.region_top  <= pwdata[RegBits-1:0];
          REG_RW:   cfg_q.region_w    <= pwdata[RegBits-1:0];
          REG_RH:   cfg_q.region_h    <= pwdata[RegBits-1:0];
          REG_OW:   cfg_q.overlay_w   <= pwdata[7:0];
          REG_OH:   cfg_q.overlay_h   <= pwdata[7:0];
          REG_SWAP: cfg_q.swap_rb     <= pwdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (opcode_e'(in_ch.opcode) == OP_LOAD) begin
          if (in_ch.pos_x < MaxOverlayW && in_ch.pos_y < MaxOverlayH)
            texels[int'(in_ch.pos_y) * MaxOverlayW + int'(in_ch.pos_x)] =
              {in_ch.chan3, in_ch.chan2, in_ch.chan1, in_ch.chan0};
        end else begin
          blend_q.push_back(blend_pixel(int'(in_ch.pos_x), int'(in_ch.pos_y),
                                        in_ch.chan0, in_ch.chan1, in_ch.chan2,
                                        in_ch.chan3));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out0: out_ch.out0, out1: out_ch.out1, out2: out_ch.out2,
                out3: out_ch.out3, blended: out_ch.blended};
        if (blend_q.size() == 0) begin
          $error("unexpected output word %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = blend_q.pop_front();
          if (got != want) begin
            fail_count_o <= fail_count_o + 1;
            if (got.out0 != want.out0) $error("out0 exp %0d got %0d", want.out0, got.out0);
            if (got.out1 != want.out1) $error("out1 exp %0d got %0d", want.out1, got.out1);
            if (got.out2 != want.out2) $error("out2 exp %0d got %0d", want.out2, got.out2);
            if (got.out3 != want.out3) $error("out3 exp %0d got %0d", want.out3, got.out3);
            if (got.blended != want.blended)
              $error("blended exp %0d got %0d", want.blended, got.blended);
          end
        end
      end
    end
  end

endmodule

// ===== test/scaled_overlay_alpha_blend_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_overlay_alpha_blend_top_test: stimulus and verdict for the blender
// Fills the reachable texels, runs directed corner pixels, then random phases
// under several region/overlay settings with varying channel back-pressure.
// ----------------------------------------------------------------------------
module scaled_overlay_alpha_blend_top_test;
  import soab_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned PhaseWords    = 180;
  // texels filled: a corner block plus thin strips along rows 0-1 and columns 0-1
  localparam int unsigned FillBlock     = 16;
  localparam int unsigned FillStrip     = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stuck_cycles = 0;
  int          cur_left = 0;
  int          cur_top = 0;
  int          cur_rw = 1;
  int          cur_rh = 1;

  soab_in_if #(.COORD_BITS(CoordBits)) in_ch ();
  soab_out_if out_ch ();

  scaled_overlay_alpha_blend_top uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_if(in_ch), .out_if(out_ch)
  );

  soab_blend_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_ch, .out_ch, .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(opcode_e op, int x, int y, logic [31:0] chans);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.pos_x  <= CoordBits'(x);
    in_ch.pos_y  <= CoordBits'(y);
    {in_ch.chan3, in_ch.chan2, in_ch.chan1, in_ch.chan0} <= chans;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic reg_write(reg_idx_e idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // loads make no word, so drain and then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_region(int left, int top, int rw, int rh, int ow, int oh, int swap);
    reg_write(REG_LEFT, left);
    reg_write(REG_TOP, top);
    reg_write(REG_RW, rw);
    reg_write(REG_RH, rh);
    reg_write(REG_OW, ow);
    reg_write(REG_OH, oh);
    reg_write(REG_SWAP, swap);
    cur_left = left;
    cur_top = top;
    cur_rw = rw;
    cur_rh = rh;
  endtask

  function automatic logic [31:0] rand_texel();
    logic [31:0] t;
    t = $urandom;
    case ($urandom_range(5))
      0: t[31:24] = 8'd0;
      1: t[31:24] = 8'd255;
      default: ;
    endcase
    return t;
  endfunction

  // mostly inside the region or just outside it, sometimes anywhere
  function automatic int near_coord(int edge_pos, int size);
    int v;
    if ($urandom_range(9) == 0) return $urandom_range(4095);
    v = edge_pos + $urandom_range(size + 1) - 1;
    if (v < 0 || v > 4095) v = $urandom_range(4095);
    return v;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(9) == 0)
          send_word(OP_LOAD, $urandom_range(4095), $urandom_range(4095), rand_texel());
        else
          send_word(OP_LOAD, $urandom_range(MaxOverlayW - 1),
                    $urandom_range(MaxOverlayH - 1), rand_texel());
      end else begin
        send_word(OP_PIXEL, near_coord(cur_left, cur_rw), near_coord(cur_top, cur_rh),
                  $urandom);
      end
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_LOAD;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    in_ch.chan0  = '0;
    in_ch.chan1  = '0;
    in_ch.chan2  = '0;
    in_ch.chan3  = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every texel that the settings below can reach gets written once
    for (int y = 0; y < MaxOverlayH; y++)
      for (int x = 0; x < MaxOverlayW; x++)
        if ((x < FillBlock && y < FillBlock) || y < FillStrip || x < FillStrip)
          send_word(OP_LOAD, x, y, rand_texel());

    // directed corners under the reset setting: 1x1 region and overlay at 0,0
    send_word(OP_LOAD, 0, 0, 32'hFF_30_80_F0);
    send_word(OP_PIXEL, 0, 0, 32'h00_00_00_00);
    send_word(OP_PIXEL, 0, 0, 32'hFF_FF_FF_FF);
    send_word(OP_PIXEL, 1, 0, 32'h12_34_56_78);
    send_word(OP_PIXEL, 0, 1, 32'h12_34_56_78);
    send_word(OP_PIXEL, 4095, 4095, 32'hFF_FF_FF_FF);
    send_word(OP_LOAD, 0, 0, 32'h00_FF_FF_FF);
    send_word(OP_PIXEL, 0, 0, 32'hAA_55_AA_55);
    send_word(OP_LOAD, 0, 0, 32'h80_01_FE_7F);
    send_word(OP_PIXEL, 0, 0, 32'h01_FE_80_00);
    send_word(OP_LOAD, MaxOverlayW, 0, 32'hFF_00_00_00);
    send_word(OP_LOAD, 0, MaxOverlayH, 32'hFF_00_00_00);
    send_word(OP_LOAD, 4095, 4095, 32'hFF_00_00_00);
    send_word(OP_PIXEL, 0, 0, 32'h01_FE_80_00);
    drain();
    set_region(0, 0, 1, 1, 1, 1, 1);
    send_word(OP_PIXEL, 0, 0, 32'h01_FE_80_00);
    send_word(OP_PIXEL, 0, 0, 32'hFF_FF_FF_FF);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      send_idle_pct = (phase < 2) ? 8 : (phase < 4) ? 68 : 0;
      recv_idle_pct = (phase < 2) ? 68 : (phase < 4) ? 8 : 0;
      case (phase)
        0: set_region(0, 0, 64, 48, 16, 12, 0);
        1: set_region(-4096, -4096, 8191, 8191, 128, 2, 1);
        2: set_region(4095, 4095, 1, 1, 255, 0, 0);
        3: set_region(100, -20, 37, 300, 200, 2, 1);
        4: set_region(-10, 3000, 0, 20, 7, 9, 0);
        5: set_region(1000, 1000, 8191, 3, 1, 128, 1);
        default: set_region($urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                             $urandom_range(1, 8191), $urandom_range(1, 8191),
                             $urandom_range(255), $urandom_range(2),
                             $urandom_range(1));
      endcase
      random_phase(PhaseWords);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
